@@ hdl/modexp_pkg.sv @@
// Shared types for the modular exponentiation block.
package modexp_pkg;

    // Status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

    // Configuration register index, taken from paddr[3]
    typedef enum logic {
        REG_MODULUS  = 1'b0,
        REG_EXPONENT = 1'b1
    } reg_idx_t;

endpackage

@@ hdl/modexp_mulmod.sv @@
// Interleaved shift-and-add modular multiplier, one multiplier bit per cycle.
module modexp_mulmod import modexp_pkg::*; #(
    parameter int WIDTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic [WIDTH-1:0] op_m,
    output mm_status_t       status,
    output logic [WIDTH-1:0] product
);

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] m_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    // (x + y) mod m with x, y below m
    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                 input logic [WIDTH-1:0] y,
                                                 input logic [WIDTH-1:0] m);
        logic [WIDTH-1:0] gap;
        gap = m - y;
        if (x >= gap) begin
            return x - gap;
        end
        return x + y;
    endfunction

    always_comb begin
        acc_next = add_mod(acc_reg, acc_reg, m_reg);
        if (b_reg[WIDTH-1]) begin
            acc_next = add_mod(acc_next, a_reg, m_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                acc_reg <= '0;
                a_reg   <= op_a;
                b_reg   <= op_b;
                m_reg   <= op_m;
            end else if (run_reg) begin
                acc_reg <= acc_next;
                b_reg   <= {b_reg[WIDTH-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = run_reg;
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule

@@ hdl/modular_exponentiation_top.sv @@
// Top level: right-to-left square-and-multiply modular exponentiation.
//
//   channel | ports                          | role
//   --------+--------------------------------+-------------------------------
//   input   | s_valid s_ready s_message      | message word to exponentiate
//   output  | m_valid m_ready m_result       | result word and zero modulus
//           | m_zero_modulus                 | flag
//   config  | psel penable pwrite paddr      | modulus at 0x0, exponent 0x8
//           | pwdata prdata pready           |
//
// One word runs one reduction, k - 1 squares and s multiplies on the single shared
// multiplier, k the exponent bit length and s its count of set bits. A zero exponent or
// zero modulus skips the multiplier. s_ready is high only while idle.
// A finished result waits in the output register while the next word is accepted; a second
// one holds until m_ready. Reset (synchronous, active low) sets modulus 1 and exponent 0.
module modular_exponentiation_top import modexp_pkg::*; #(
    parameter int WIDTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [WIDTH-1:0] s_message,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [WIDTH-1:0] m_result,
    output logic             m_zero_modulus,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_MUL,
        S_SQR,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] exponent_reg;
    logic [WIDTH-1:0] m_reg;
    logic [WIDTH-1:0] e_reg;
    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] acc_reg;
    logic             flag_reg;
    logic             start_reg;
    logic [WIDTH-1:0] op_a_reg;
    logic [WIDTH-1:0] op_b_reg;
    logic             m_valid_reg;
    logic [WIDTH-1:0] m_result_reg;
    logic             m_zero_modulus_reg;
    mm_status_t       mm_status;
    logic [WIDTH-1:0] product;
    logic [WIDTH-1:0] e_shift;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3]);
    assign prdata  = (cfg_idx == REG_EXPONENT) ? 64'(exponent_reg) : 64'(modulus_reg);
    assign e_shift = e_reg >> 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= WIDTH'(1);
            exponent_reg <= '0;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                REG_MODULUS:  modulus_reg  <= pwdata[WIDTH-1:0];
                REG_EXPONENT: exponent_reg <= pwdata[WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    modexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .op_a    (op_a_reg),
        .op_b    (op_b_reg),
        .op_m    (m_reg),
        .status  (mm_status),
        .product (product)
    );

    assign s_ready        = (state_reg == S_IDLE) && !mm_status.busy;
    assign m_valid        = m_valid_reg;
    assign m_result       = m_result_reg;
    assign m_zero_modulus = m_zero_modulus_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        m_reg    <= modulus_reg;
                        e_reg    <= exponent_reg;
                        flag_reg <= 1'b0;
                        if (exponent_reg == '0) begin
                            acc_reg   <= WIDTH'(1);
                            state_reg <= S_DONE;
                        end else if (modulus_reg == '0) begin
                            acc_reg   <= '0;
                            flag_reg  <= 1'b1;
                            state_reg <= S_DONE;
                        end else begin
                            // 1 mod m, then reduce the message as (1 mod m) * msg
                            acc_reg   <= (modulus_reg == WIDTH'(1)) ? '0 : WIDTH'(1);
                            op_a_reg  <= (modulus_reg == WIDTH'(1)) ? '0 : WIDTH'(1);
                            op_b_reg  <= s_message;
                            start_reg <= 1'b1;
                            state_reg <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (mm_status.done) begin
                        base_reg  <= product;
                        start_reg <= 1'b1;
                        if (e_reg[0]) begin
                            op_a_reg  <= acc_reg;
                            op_b_reg  <= product;
                            state_reg <= S_MUL;
                        end else begin
                            op_a_reg  <= product;
                            op_b_reg  <= product;
                            state_reg <= S_SQR;
                        end
                    end
                end
                S_MUL: begin
                    if (mm_status.done) begin
                        acc_reg <= product;
                        if (e_shift == '0) begin
                            state_reg <= S_DONE;
                        end else begin
                            op_a_reg  <= base_reg;
                            op_b_reg  <= base_reg;
                            start_reg <= 1'b1;
                            state_reg <= S_SQR;
                        end
                    end
                end
                S_SQR: begin
                    if (mm_status.done) begin
                        base_reg  <= product;
                        e_reg     <= e_shift;
                        start_reg <= 1'b1;
                        op_b_reg  <= product;
                        if (e_shift[0]) begin
                            op_a_reg  <= acc_reg;
                            state_reg <= S_MUL;
                        end else begin
                            op_a_reg  <= product;
                            state_reg <= S_SQR;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the output slot is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_result_reg       <= acc_reg;
                        m_zero_modulus_reg <= flag_reg;
                        state_reg          <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ tb/modular_exponentiation_top_tb.sv @@
// Self-checking testbench for the modular exponentiation block.
module modular_exponentiation_top_tb import modexp_pkg::*;;

    localparam logic [63:0] ALL1          = '1;
    localparam int          N_VEC         = 22;
    localparam int          N_RANDOM      = 120;
    localparam int          HOLD_AT       = N_VEC + 3;
    localparam int          HOLD_CYCLES   = 6000;
    localparam int          BURST_LO      = N_VEC + 40;
    localparam int          BURST_HI      = N_VEC + 90;
    localparam int          STALL_LIMIT   = 80000;
    localparam int          TAIL_CYCLES   = 200;
    localparam int          REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [63:0] result;
        logic        zero_mod;
    } modexp_word_t;

    typedef struct packed {
        logic [63:0] modulus;
        logic [63:0] exponent;
        logic [63:0] message;
        logic        known;
        logic [63:0] result;
        logic        zero_mod;
    } vector_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [63:0] s_message      = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [63:0] m_result;
    logic        m_zero_modulus;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [3:0]  paddr          = '0;
    logic [63:0] pwdata         = '0;
    logic [63:0] prdata;
    logic        pready;

    // expectation that travels with the word currently offered
    modexp_word_t s_expect      = '0;
    modexp_word_t expected_words [$];

    logic [63:0] cfg_modulus    = 64'd1;
    logic [63:0] cfg_exponent   = 64'd0;
    int          words_in       = 0;
    int          words_out      = 0;
    int          mismatch_count = 0;
    int          stall_cycles   = 0;

    // modulus, exponent, message, known, result, zero_modulus
    vector_t vectors [N_VEC] = '{
        '{64'd1, 64'd0, 64'd123, 1'b1, 64'd1, 1'b0},          // reset values
        '{64'd0, 64'd0, ALL1, 1'b1, 64'd1, 1'b0},             // zero exponent wins
        '{64'd0, 64'd5, 64'd7, 1'b1, 64'd0, 1'b1},
        '{64'd0, ALL1, 64'd0, 1'b1, 64'd0, 1'b1},
        '{64'd1, ALL1, ALL1, 1'b1, 64'd0, 1'b0},
        '{64'd1, 64'd1, 64'd5, 1'b1, 64'd0, 1'b0},
        '{64'd1, 64'd0, 64'd9, 1'b1, 64'd1, 1'b0},
        '{ALL1, 64'd1, ALL1, 1'b1, 64'd0, 1'b0},              // message equals modulus
        '{ALL1, 64'd1, ALL1 - 1, 1'b1, ALL1 - 1, 1'b0},
        '{ALL1, 64'd2, ALL1 - 1, 1'b1, 64'd1, 1'b0},          // (-1)^2
        '{ALL1, ALL1, 64'd0, 1'b1, 64'd0, 1'b0},
        '{ALL1, ALL1, 64'd1, 1'b1, 64'd1, 1'b0},
        '{ALL1, ALL1, 64'h0123_4567_89AB_CDEF, 1'b0, 64'd0, 1'b0},
        '{64'd13, 64'd0, 64'd0, 1'b1, 64'd1, 1'b0},
        '{64'd13, 64'd5, 64'd0, 1'b1, 64'd0, 1'b0},
        '{64'd13, 64'd5, ALL1, 1'b0, 64'd0, 1'b0},            // unreduced message
        '{64'd3233, 64'd17, 64'd65, 1'b0, 64'd0, 1'b0},
        '{64'd3233, 64'd2753, 64'd2790, 1'b0, 64'd0, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFC5, 64'd2, ALL1, 1'b0, 64'd0, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC4, 64'd2, 1'b0, 64'd0, 1'b0},
        '{64'h8000_0000_0000_0000, ALL1, 64'd3, 1'b0, 64'd0, 1'b0},
        '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
          64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0, 1'b0}
    };

    modular_exponentiation_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message      (s_message),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result       (m_result),
        .m_zero_modulus (m_zero_modulus),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] mul_reduce(input logic [63:0] a, b, n);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod % {64'd0, n};
        return prod[63:0];
    endfunction

    function automatic modexp_word_t power_mod(input logic [63:0] n, e, msg);
        modexp_word_t w;
        logic [63:0]  acc;
        logic [63:0]  sq;
        w.result   = 64'd0;
        w.zero_mod = 1'b0;
        if (e == 64'd0) begin
            w.result = 64'd1;
        end else if (n == 64'd0) begin
            w.zero_mod = 1'b1;
        end else begin
            acc = (n == 64'd1) ? 64'd0 : 64'd1;
            sq  = msg % n;
            for (int i = 0; i < 64; i++) begin
                if (e[i]) acc = mul_reduce(acc, sq, n);
                sq = mul_reduce(sq, sq, n);
            end
            w.result = acc;
        end
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit in_burst();
        return words_in >= BURST_LO && words_in < BURST_HI;
    endfunction

    function automatic logic [63:0] pick_modulus();
        case ($urandom_range(9))
            0: return 64'd0;
            1: return 64'd1;
            2: return ALL1;
            3: return 64'($urandom_range(1000, 2));
            4: return 64'd1 << $urandom_range(63);
            5: return rand64() | 64'd1;
            default: return rand64();
        endcase
    endfunction

    function automatic logic [63:0] pick_exponent();
        case ($urandom_range(9))
            0: return 64'd0;
            1: return rand64();
            2: return ALL1;
            3: return 64'($urandom);
            4: return 64'($urandom_range(65535, 1));
            default: return 64'($urandom_range(255, 1));
        endcase
    endfunction

    function automatic logic [63:0] pick_message();
        case ($urandom_range(9))
            0: return 64'd0;
            1: return 64'd1;
            2: return ALL1;
            3: return cfg_modulus - 64'd1;
            4: return cfg_modulus;
            5: return 64'($urandom_range(1000));
            default: return rand64();
        endcase
    endfunction

    task automatic note_failure(input string text);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("%s", text);
    endtask

    // let at least one edge pass so the counters reflect the last handshake
    task automatic wait_drained();
        do @(posedge aclk); while (words_out != words_in);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MODULUS) cfg_modulus = val;
        else cfg_exponent = val;
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [63:0] n, e, input bit write_all);
        if (write_all || n != cfg_modulus || e != cfg_exponent) begin
            s_valid <= 1'b0;
            wait_drained();
            if (write_all || n != cfg_modulus) apb_write(REG_MODULUS, n);
            if (write_all || e != cfg_exponent) apb_write(REG_EXPONENT, e);
        end
    endtask

    // valid stays high across back-to-back words; only a gap or a config load lowers it
    task automatic send_message(input logic [63:0] msg, input modexp_word_t want);
        int gap;
        gap = 0;
        if (!in_burst()) while ($urandom_range(99) < 14) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_message <= msg;
        s_expect  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin : receiver
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            // hold off long enough for the block to fill and drop s_ready
            if (aresetn && !held && words_in >= HOLD_AT) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= aresetn && (in_burst() || $urandom_range(99) >= 14);
        end
    end

    always @(posedge aclk) begin : monitor
        modexp_word_t got;
        modexp_word_t want;
        if (aresetn) begin
            // pop before push so a stray word never meets its own expectation
            if (m_valid && m_ready) begin
                words_out <= words_out + 1;
                got = '{m_result, m_zero_modulus};
                if (expected_words.size() == 0) begin
                    note_failure($sformatf("unexpected word: result %h zero_modulus %b",
                                           got.result, got.zero_mod));
                end else begin
                    want = expected_words.pop_front();
                    if (got.result !== want.result || got.zero_mod !== want.zero_mod)
                        note_failure($sformatf(
                            "word %0d: result %h zero_modulus %b, expected %h %b",
                            words_out, got.result, got.zero_mod,
                            want.result, want.zero_mod));
                end
            end
            if (s_valid && s_ready) begin
                expected_words.push_back(s_expect);
                words_in <= words_in + 1;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int           sent;
        int           batch;
        int           phase;
        logic [63:0]  n_sel;
        logic [63:0]  e_sel;
        logic [63:0]  msg;
        modexp_word_t want;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_VEC; i++) begin
            load_config(vectors[i].modulus, vectors[i].exponent, 1'b0);
            if (vectors[i].known) begin
                want.result   = vectors[i].result;
                want.zero_mod = vectors[i].zero_mod;
            end else begin
                want = power_mod(cfg_modulus, cfg_exponent, vectors[i].message);
            end
            send_message(vectors[i].message, want);
        end

        sent  = 0;
        phase = 0;
        while (sent < N_RANDOM) begin
            if (phase == 0) begin
                // short exponent so the receiver hold-off backs the block up
                n_sel = rand64() | 64'd1;
                e_sel = 64'd65537;
            end else begin
                n_sel = pick_modulus();
                e_sel = pick_exponent();
            end
            load_config(n_sel, e_sel, 1'b1);
            batch = (e_sel > 64'hFFFF_FFFF) ? 4 : 14;
            for (int k = 0; k < batch; k++) begin
                msg = pick_message();
                send_message(msg, power_mod(cfg_modulus, cfg_exponent, msg));
            end
            sent += batch;
            phase++;
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/modexp_pkg.sv
hdl/modexp_mulmod.sv
hdl/modular_exponentiation_top.sv
tb/modular_exponentiation_top_tb.sv
